[hw/rtl/prsnt_pkg.sv]
// Shared types, constants and layer functions for the PRESENT cipher block
`default_nettype none

package prsnt_pkg;

  localparam int BLOCK_W   = 64;
  localparam int KEY_W     = 128;
  localparam int NUM_KEYS  = 32;
  localparam int STEP_W    = $clog2(NUM_KEYS);
  localparam int CFG_IDX_W = 2;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_KEYS - 1);

  typedef logic [1:0]           kind_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // item kinds
  localparam kind_t KIND_ENC  = 2'd0;
  localparam kind_t KIND_DEC  = 2'd1;
  localparam kind_t KIND_CTR  = 2'd2;
  localparam kind_t KIND_NONE = 2'd3;

  // register indexes
  localparam cfg_idx_t REG_KEY_SIZE = 2'd0;
  localparam cfg_idx_t REG_KEY_HIGH = 2'd1;
  localparam cfg_idx_t REG_KEY_LOW  = 2'd2;
  localparam cfg_idx_t REG_NONCE    = 2'd3;

  // commands from controller to datapath
  typedef struct packed {
    logic              load_item;
    logic              key_write;
    logic              key_done;
    logic              round_en;
    logic              out_load;
    logic [STEP_W-1:0] step;
    logic [STEP_W-1:0] rd_step;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic keys_ready;
  } stat_t;

  localparam logic [3:0] SBOX_FWD [16] = '{
    4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
    4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
  };
  localparam logic [3:0] SBOX_INV [16] = '{
    4'h5, 4'hE, 4'hF, 4'h8, 4'hC, 4'h1, 4'h2, 4'hD,
    4'hB, 4'h4, 4'h6, 4'h3, 4'h0, 4'h7, 4'h9, 4'hA
  };

  // bit i of the state moves to 16*i mod 63, the top bit stays put
  function automatic int perm_dest(input int i);
    return (i == BLOCK_W - 1) ? (BLOCK_W - 1) : ((i % 4) * 16 + i / 4);
  endfunction

  function automatic logic [BLOCK_W-1:0] sub_fwd(input logic [BLOCK_W-1:0] s);
    logic [BLOCK_W-1:0] o;
    for (int i = 0; i < BLOCK_W / 4; i++) begin
      o[4*i +: 4] = SBOX_FWD[s[4*i +: 4]];
    end
    return o;
  endfunction

  function automatic logic [BLOCK_W-1:0] sub_inv(input logic [BLOCK_W-1:0] s);
    logic [BLOCK_W-1:0] o;
    for (int i = 0; i < BLOCK_W / 4; i++) begin
      o[4*i +: 4] = SBOX_INV[s[4*i +: 4]];
    end
    return o;
  endfunction

  function automatic logic [BLOCK_W-1:0] perm_fwd(input logic [BLOCK_W-1:0] s);
    logic [BLOCK_W-1:0] o;
    for (int i = 0; i < BLOCK_W; i++) begin
      o[6'(perm_dest(i))] = s[i];
    end
    return o;
  endfunction

  function automatic logic [BLOCK_W-1:0] perm_inv(input logic [BLOCK_W-1:0] s);
    logic [BLOCK_W-1:0] o;
    for (int i = 0; i < BLOCK_W; i++) begin
      o[i] = s[6'(perm_dest(i))];
    end
    return o;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/prsnt_ctrl.sv]
// Controller state machine sequencing key expansion, rounds and result hand-off
`default_nettype none

module prsnt_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_valid,
  output logic                 item_stall,
  input  wire prsnt_pkg::kind_t kind,
  output logic                 result_valid,
  input  wire logic            result_stall,
  input  wire prsnt_pkg::stat_t stat,
  output prsnt_pkg::cmd_t      cmd
);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_EXPAND   = 5'b00010,
    ST_PREFETCH = 5'b00100,
    ST_RUN      = 5'b01000,
    ST_FINISH   = 5'b10000
  } state_t;

  state_t                         state, state_next;
  logic [prsnt_pkg::STEP_W-1:0]   cnt, cnt_next;
  logic                           accept;
  logic                           out_free;

  // one item in flight at a time
  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && (state == ST_IDLE);
  assign out_free   = !result_valid || !result_stall;

  // next state and commands
  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    cmd           = '0;
    cmd.step      = cnt;
    cmd.load_item = accept;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cnt_next = '0;
          if (kind == prsnt_pkg::KIND_NONE) begin
            state_next = ST_FINISH;
          end else if (!stat.keys_ready) begin
            state_next = ST_EXPAND;
          end else begin
            state_next = ST_PREFETCH;
          end
        end
      end
      ST_EXPAND: begin
        cmd.key_write = 1'b1;
        cnt_next      = cnt + 1'b1;
        if (cnt == prsnt_pkg::LAST_STEP) begin
          cmd.key_done = 1'b1;
          state_next   = ST_PREFETCH;
        end
      end
      ST_PREFETCH: begin
        cmd.rd_step = '0;
        cnt_next    = '0;
        state_next  = ST_RUN;
      end
      ST_RUN: begin
        cmd.round_en = 1'b1;
        cmd.rd_step  = cnt + 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == prsnt_pkg::LAST_STEP) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/prsnt_dp.sv]
// Datapath: registers, key schedule, round key memory, round unit and result register
`default_nettype none

module prsnt_dp (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire prsnt_pkg::cmd_t                   cmd,
  output prsnt_pkg::stat_t                       stat,
  input  wire logic                              cfg_write,
  input  wire prsnt_pkg::cfg_idx_t               cfg_index,
  input  wire logic [prsnt_pkg::BLOCK_W-1:0]     cfg_data,
  input  wire prsnt_pkg::kind_t                  kind,
  input  wire logic [prsnt_pkg::BLOCK_W-1:0]     data_block,
  input  wire logic                              restart_counter,
  output logic [prsnt_pkg::BLOCK_W-1:0]          result_block
);

  logic                              key_size_mode;
  logic [prsnt_pkg::BLOCK_W-1:0]     key_high;
  logic [prsnt_pkg::BLOCK_W-1:0]     key_low;
  logic [prsnt_pkg::BLOCK_W-1:0]     ctr_nonce;
  logic                              keys_ready;
  logic [prsnt_pkg::BLOCK_W-1:0]     block_counter;
  logic [prsnt_pkg::BLOCK_W-1:0]     ctr_base;

  prsnt_pkg::kind_t                  item_kind;
  logic [prsnt_pkg::BLOCK_W-1:0]     item_data;
  logic [prsnt_pkg::BLOCK_W-1:0]     st, st_next;

  logic [prsnt_pkg::KEY_W-1:0]       sk, sk_next;
  logic [prsnt_pkg::BLOCK_W-1:0]     rk_out;
  logic [prsnt_pkg::STEP_W-1:0]      rc;
  logic [79:0]                       rot80;
  logic [prsnt_pkg::KEY_W-1:0]       rot128;

  logic [prsnt_pkg::BLOCK_W-1:0]     rk_mem [prsnt_pkg::NUM_KEYS];
  logic [prsnt_pkg::BLOCK_W-1:0]     rk_q;
  logic [prsnt_pkg::STEP_W-1:0]      rd_addr;

  assign stat.keys_ready = keys_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_size_mode <= 1'b0;
      key_high      <= '0;
      key_low       <= '0;
      ctr_nonce     <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        prsnt_pkg::REG_KEY_SIZE: key_size_mode <= cfg_data[0];
        prsnt_pkg::REG_KEY_HIGH: key_high      <= cfg_data;
        prsnt_pkg::REG_KEY_LOW:  key_low       <= cfg_data;
        prsnt_pkg::REG_NONCE:    ctr_nonce     <= cfg_data;
        default: ;
      endcase
    end
  end

  // round keys go stale on any key or key-size write
  always_ff @(posedge clk) begin
    if (rst) begin
      keys_ready <= 1'b0;
    end else if (cfg_write && (cfg_index != prsnt_pkg::REG_NONCE)) begin
      keys_ready <= 1'b0;
    end else if (cmd.key_done) begin
      keys_ready <= 1'b1;
    end
  end

  // block counter, restarted on request and bumped once per counter-mode item
  assign ctr_base = restart_counter ? '0 : block_counter;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_counter <= '0;
    end else if (cmd.load_item && (kind == prsnt_pkg::KIND_CTR)) begin
      block_counter <= ctr_base + 1'b1;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_kind <= kind;
      item_data <= data_block;
    end
  end

  // key schedule step: rotate, s-box on the top nibble(s), xor round counter
  assign rc = cmd.step + 1'b1;

  always_comb begin
    rot128 = {sk[66:0], sk[127:67]};
    rot128[127:124] = prsnt_pkg::SBOX_FWD[rot128[127:124]];
    rot128[123:120] = prsnt_pkg::SBOX_FWD[rot128[123:120]];
    rot128[66:62]   = rot128[66:62] ^ rc;
    rot80 = {sk[18:0], sk[79:19]};
    rot80[79:76] = prsnt_pkg::SBOX_FWD[rot80[79:76]];
    rot80[19:15] = rot80[19:15] ^ rc;
    if (key_size_mode) begin
      sk_next = rot128;
      rk_out  = sk[127:64];
    end else begin
      sk_next = {48'b0, rot80};
      rk_out  = sk[79:16];
    end
  end

  // key register, loaded from the key registers with each item
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      if (key_size_mode) begin
        sk <= {key_high, key_low};
      end else begin
        sk <= {48'b0, key_high, key_low[15:0]};
      end
    end else if (cmd.key_write) begin
      sk <= sk_next;
    end
  end

  // round key memory, decrypt walks the keys from the top down
  assign rd_addr = (item_kind == prsnt_pkg::KIND_DEC) ? ~cmd.rd_step : cmd.rd_step;

  always_ff @(posedge clk) begin
    if (cmd.key_write) begin
      rk_mem[cmd.step] <= rk_out;
    end
  end

  always_ff @(posedge clk) begin
    rk_q <= rk_mem[rd_addr];
  end

  // one round per step; the lone key xor comes last for encrypt, first for decrypt
  always_comb begin
    if (item_kind == prsnt_pkg::KIND_DEC) begin
      if (cmd.step == '0) begin
        st_next = st ^ rk_q;
      end else begin
        st_next = prsnt_pkg::sub_inv(prsnt_pkg::perm_inv(st)) ^ rk_q;
      end
    end else begin
      if (cmd.step == prsnt_pkg::LAST_STEP) begin
        st_next = st ^ rk_q;
      end else begin
        st_next = prsnt_pkg::perm_fwd(prsnt_pkg::sub_fwd(st ^ rk_q));
      end
    end
  end

  // cipher state
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      if (kind == prsnt_pkg::KIND_CTR) begin
        st <= ctr_nonce ^ ctr_base;
      end else begin
        st <= data_block;
      end
    end else if (cmd.round_en) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (item_kind)
        prsnt_pkg::KIND_CTR:  result_block <= item_data ^ st;
        prsnt_pkg::KIND_NONE: result_block <= '0;
        default:              result_block <= st;
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/present_block_cipher_ctr.sv]
// Top level of the PRESENT block cipher with encrypt, decrypt and counter mode
`default_nettype none

// PRESENT 64-bit block cipher, 80- or 128-bit key, one item at a time. An encrypt,
// decrypt or counter-mode item runs from acceptance to the next free acceptance
// slot through a prefetch state, 32 steps of the single round unit (31 rounds
// plus the lone key xor), and a finish state that loads the result register once
// it is free; each step waits on the registered read of the 32-entry round key
// memory. The first such item after reset or after a write to key_size_mode,
// key_high or key_low first writes the round key schedule into that memory, one
// key per cycle. Kind 3 goes straight to the finish state and loads a zero result.
// The result register lets the next item be taken while the previous result is
// still stalled. Configuration writes are always ready and must only be made
// while no item is in flight.
module present_block_cipher_ctr (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  output logic                               item_stall,
  input  wire logic [1:0]                    kind,
  input  wire logic [63:0]                   data_block,
  input  wire logic                          restart_counter,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output logic [63:0]                        result_block,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [63:0]                   cfg_data
);

  prsnt_pkg::cmd_t  cmd;
  prsnt_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  // sequencing
  prsnt_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .kind         (kind),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  // storage and round logic
  prsnt_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_write       (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .kind            (kind),
    .data_block      (data_block),
    .restart_counter (restart_counter),
    .result_block    (result_block)
  );

  // the block is busy in the cycle after it takes an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> item_stall)
    else $error("item taken while previous item still in flight");

  // a key or key-size write always invalidates the round keys
  a_keys_stale: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && (cfg_index != prsnt_pkg::REG_NONCE)) |=> !stat.keys_ready)
    else $error("round keys still marked ready after key write");

  // a new result never overwrites one that is still stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(result_valid && result_stall))
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

[test/present_block_cipher_ctr_tb.sv]
// Self-checking testbench for the PRESENT cipher block: directed and random items
`timescale 1ns / 1ps

module present_block_cipher_ctr_tb;

  localparam int RANDOM_ITEMS = 740;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 80;

  localparam logic [3:0] NIB_FWD [16] = '{
    4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
    4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
  };
  localparam logic [3:0] NIB_INV [16] = '{
    4'h5, 4'hE, 4'hF, 4'h8, 4'hC, 4'h1, 4'h2, 4'hD,
    4'hB, 4'h4, 4'h6, 4'h3, 4'h0, 4'h7, 4'h9, 4'hA
  };

  logic                clk = 1'b0;
  logic                rst;
  logic                item_valid;
  logic                item_stall;
  prsnt_pkg::kind_t    kind;
  logic [63:0]         data_block;
  logic                restart_counter;
  logic                result_valid;
  logic                result_stall;
  logic [63:0]         result_block;
  logic                cfg_valid;
  logic                cfg_ready;
  prsnt_pkg::cfg_idx_t cfg_index;
  logic [63:0]         cfg_data;

  // shadow of the cipher state and registers
  logic        mdl_size128;
  logic [63:0] mdl_key_hi;
  logic [63:0] mdl_key_lo;
  logic [63:0] mdl_nonce;
  logic [63:0] mdl_counter;
  logic [63:0] mdl_round_keys [32];
  logic        mdl_keys_fresh;

  logic [63:0] pending_blocks [$];
  logic [63:0] last_prediction;
  int          mismatches = 0;
  bit          send_gaps = 1'b1;
  bit          recv_gaps = 1'b1;
  bit          long_hold_req = 1'b0;

  present_block_cipher_ctr uut (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (item_valid),
    .item_stall      (item_stall),
    .kind            (kind),
    .data_block      (data_block),
    .restart_counter (restart_counter),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .result_block    (result_block),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  // bit i of the state goes to 16*i mod 63, the top bit stays
  function automatic int bit_dest(int i);
    return (i == 63) ? 63 : (16 * i) % 63;
  endfunction

  function automatic logic [63:0] nibble_sub(logic [63:0] s, bit inverse);
    logic [63:0] o;
    for (int i = 0; i < 16; i++) begin
      o[4*i +: 4] = inverse ? NIB_INV[s[4*i +: 4]] : NIB_FWD[s[4*i +: 4]];
    end
    return o;
  endfunction

  function automatic logic [63:0] bit_scatter(logic [63:0] s);
    logic [63:0] o;
    for (int i = 0; i < 64; i++) begin
      o[bit_dest(i)] = s[i];
    end
    return o;
  endfunction

  function automatic logic [63:0] bit_gather(logic [63:0] s);
    logic [63:0] o;
    for (int i = 0; i < 64; i++) begin
      o[i] = s[bit_dest(i)];
    end
    return o;
  endfunction

  // round key schedule from the shadow key registers
  function automatic void build_schedule();
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] nh;
    logic [63:0] nl;
    if (mdl_size128) begin
      hi = mdl_key_hi;
      lo = mdl_key_lo;
      for (int r = 0; r < 32; r++) begin
        mdl_round_keys[r] = hi;
        nh = (hi << 61) | (lo >> 3);
        nl = (lo << 61) | (hi >> 3);
        hi = nh;
        lo = nl;
        hi[63:60] = NIB_FWD[hi[63:60]];
        hi[59:56] = NIB_FWD[hi[59:56]];
        hi = hi ^ 64'(((r + 1) & 31) >> 2);
        lo[63:62] = lo[63:62] ^ 2'((r + 1) & 3);
      end
    end else begin
      // 80-bit key: top 16 bits in hi, lower 64 bits in lo
      hi = {48'd0, mdl_key_hi[63:48]};
      lo = {mdl_key_hi[47:0], mdl_key_lo[15:0]};
      for (int r = 0; r < 32; r++) begin
        mdl_round_keys[r] = {hi[15:0], lo[63:16]};
        nh = (lo >> 3) & 64'hFFFF;
        nl = (lo >> 19) | (hi << 45) | (lo << 61);
        hi = nh;
        lo = nl;
        hi[15:12] = NIB_FWD[hi[15:12]];
        lo = lo ^ (64'((r + 1) & 31) << 15);
      end
    end
    mdl_keys_fresh = 1'b1;
  endfunction

  function automatic logic [63:0] encipher(logic [63:0] s);
    for (int r = 0; r < 31; r++) begin
      s = bit_scatter(nibble_sub(s ^ mdl_round_keys[r], 1'b0));
    end
    return s ^ mdl_round_keys[31];
  endfunction

  function automatic logic [63:0] decipher(logic [63:0] s);
    s = s ^ mdl_round_keys[31];
    for (int r = 31; r > 0; r--) begin
      s = nibble_sub(bit_gather(s), 1'b1) ^ mdl_round_keys[r-1];
    end
    return s;
  endfunction

  // expected output block for one item, advancing the shadow state
  function automatic logic [63:0] predict_block(prsnt_pkg::kind_t k, logic [63:0] d,
                                                logic r);
    logic [63:0] res;
    res = '0;
    if (k != prsnt_pkg::KIND_NONE && !mdl_keys_fresh) build_schedule();
    case (k)
      prsnt_pkg::KIND_ENC: res = encipher(d);
      prsnt_pkg::KIND_DEC: res = decipher(d);
      prsnt_pkg::KIND_CTR: begin
        if (r) mdl_counter = '0;
        res = d ^ encipher(mdl_nonce ^ mdl_counter);
        mdl_counter = mdl_counter + 64'd1;
      end
      default: res = '0;
    endcase
    return res;
  endfunction

  function automatic void note_register(prsnt_pkg::cfg_idx_t idx, logic [63:0] v);
    case (idx)
      prsnt_pkg::REG_KEY_SIZE: begin
        mdl_size128    = v[0];
        mdl_keys_fresh = 1'b0;
      end
      prsnt_pkg::REG_KEY_HIGH: begin
        mdl_key_hi     = v;
        mdl_keys_fresh = 1'b0;
      end
      prsnt_pkg::REG_KEY_LOW: begin
        mdl_key_lo     = v;
        mdl_keys_fresh = 1'b0;
      end
      prsnt_pkg::REG_NONCE: mdl_nonce = v;
      default: ;
    endcase
  endfunction

  function automatic logic [63:0] rand_block();
    return {$urandom(), $urandom()};
  endfunction

  // random block, all zeros or all ones now and then
  function automatic logic [63:0] pick_block();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return rand_block();
  endfunction

  task automatic flag_mismatch(string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // offer one item and record its expected output once accepted
  task automatic send_block(prsnt_pkg::kind_t k, logic [63:0] d, logic r);
    int gap;
    gap = send_gaps ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid      <= 1'b1;
    kind            <= k;
    data_block      <= d;
    restart_counter <= r;
    do @(posedge clk); while (item_stall);
    last_prediction = predict_block(k, d, r);
    pending_blocks.push_back(last_prediction);
  endtask

  // stop offering and wait until every expected block has come back
  task automatic settle();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending_blocks.size() != 0);
  endtask

  task automatic write_register(prsnt_pkg::cfg_idx_t idx, logic [63:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    note_register(idx, v);
  endtask

  // write the selected registers once the block is idle
  task automatic program_cipher(logic [3:0] sel, logic size, logic [63:0] hi,
                                logic [63:0] lo, logic [63:0] nonce);
    logic [63:0] v;
    settle();
    if (sel[prsnt_pkg::REG_KEY_SIZE]) begin
      v    = rand_block();
      v[0] = size;
      write_register(prsnt_pkg::REG_KEY_SIZE, v);
    end
    if (sel[prsnt_pkg::REG_KEY_HIGH]) write_register(prsnt_pkg::REG_KEY_HIGH, hi);
    if (sel[prsnt_pkg::REG_KEY_LOW]) write_register(prsnt_pkg::REG_KEY_LOW, lo);
    if (sel[prsnt_pkg::REG_NONCE]) write_register(prsnt_pkg::REG_NONCE, nonce);
    cfg_valid <= 1'b0;
  endtask

  // receiver: check each output block, then hold off for a drawn number of cycles
  initial begin : result_sink
    int hold;
    logic [63:0] want;
    hold = 0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) begin
        if (pending_blocks.size() == 0) begin
          flag_mismatch($sformatf("unexpected result_block %h", result_block));
        end else begin
          want = pending_blocks.pop_front();
          if (result_block !== want)
            flag_mismatch($sformatf("result_block %h, expected %h", result_block, want));
        end
        hold = recv_gaps ? $urandom_range(0, 5) : 0;
        result_stall <= (hold > 0);
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = LONG_HOLD;
        result_stall <= 1'b1;
      end else if (hold > 0) begin
        hold--;
        result_stall <= (hold > 0);
      end
    end
  end

  // reset key values: expansion on the first item, restart ignored off counter mode
  task automatic test_reset_defaults();
    send_block(prsnt_pkg::KIND_ENC, '0, 1'b0);
    send_block(prsnt_pkg::KIND_ENC, '1, 1'b1);
    send_block(prsnt_pkg::KIND_DEC, '0, 1'b1);
    send_block(prsnt_pkg::KIND_DEC, '1, 1'b0);
    send_block(prsnt_pkg::KIND_CTR, '0, 1'b1);
    send_block(prsnt_pkg::KIND_CTR, '1, 1'b0);
    send_block(prsnt_pkg::KIND_CTR, rand_block(), 1'b0);
    send_block(prsnt_pkg::KIND_NONE, '1, 1'b1);
  endtask

  // all-ones 80-bit key with its unused key bits set, all-zero and all-ones 128-bit keys
  task automatic test_key_extremes();
    program_cipher(4'hF, 1'b0, '1, '1, '1);
    send_block(prsnt_pkg::KIND_ENC, '1, 1'b0);
    send_block(prsnt_pkg::KIND_DEC, '0, 1'b0);
    send_block(prsnt_pkg::KIND_CTR, '0, 1'b1);
    program_cipher(4'h7, 1'b1, '0, '0, '0);
    send_block(prsnt_pkg::KIND_ENC, '0, 1'b0);
    send_block(prsnt_pkg::KIND_DEC, '1, 1'b0);
    program_cipher(4'h6, 1'b1, '1, '1, '0);
    send_block(prsnt_pkg::KIND_ENC, '1, 1'b0);
    send_block(prsnt_pkg::KIND_DEC, '0, 1'b0);
    send_block(prsnt_pkg::KIND_CTR, '1, 1'b0);
  endtask

  // nonce write keeps the counter and the keys, key size write forces re-expansion
  task automatic test_nonce_keeps_counter();
    send_block(prsnt_pkg::KIND_CTR, rand_block(), 1'b1);
    send_block(prsnt_pkg::KIND_CTR, rand_block(), 1'b0);
    program_cipher(4'h8, 1'b0, '0, '0, rand_block());
    send_block(prsnt_pkg::KIND_CTR, rand_block(), 1'b0);
    program_cipher(4'h1, 1'b1, '0, '0, '0);
    send_block(prsnt_pkg::KIND_ENC, rand_block(), 1'b0);
  endtask

  // receiver holds off for a long stretch while items keep coming
  task automatic test_backpressure();
    send_gaps     = 1'b0;
    long_hold_req = 1'b1;
    repeat (24) send_block(prsnt_pkg::kind_t'($urandom_range(0, 2)), rand_block(),
                           1'(($urandom())));
    send_gaps = 1'b1;
  endtask

  // phases of random settings, each carrying well-formed sequences with random content
  task automatic test_random_traffic();
    int sent;
    int budget;
    int run;
    logic [63:0] d;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      program_cipher(($urandom_range(0, 3) == 0) ? 4'hF : 4'($urandom()),
                     1'($urandom()), pick_block(), pick_block(), pick_block());
      send_gaps = ($urandom_range(0, 3) != 0);
      recv_gaps = ($urandom_range(0, 3) != 0);
      budget    = $urandom_range(30, 70);
      while (budget > 0) begin
        case ($urandom_range(0, 2))
          // encrypt then decrypt the prediction, or the other way round
          0: begin
            d = pick_block();
            if ($urandom_range(0, 1)) begin
              send_block(prsnt_pkg::KIND_ENC, d, 1'($urandom()));
              send_block(prsnt_pkg::KIND_DEC, last_prediction, 1'($urandom()));
            end else begin
              send_block(prsnt_pkg::KIND_DEC, d, 1'($urandom()));
              send_block(prsnt_pkg::KIND_ENC, last_prediction, 1'($urandom()));
            end
            run = 2;
          end
          // counter-mode stream, usually started afresh
          1: begin
            run = $urandom_range(2, 8);
            send_block(prsnt_pkg::KIND_CTR, pick_block(), ($urandom_range(0, 3) != 0));
            repeat (run - 1) send_block(prsnt_pkg::KIND_CTR, pick_block(), 1'b0);
          end
          // single item of any kind, the unused kind now and then
          default: begin
            if ($urandom_range(0, 7) == 0) begin
              send_block(prsnt_pkg::KIND_NONE, pick_block(), 1'($urandom()));
              run = 0;
            end else begin
              send_block(prsnt_pkg::kind_t'($urandom_range(0, 2)), pick_block(),
                         1'($urandom()));
              run = 1;
            end
          end
        endcase
        budget -= (run == 0) ? 1 : run;
        sent   += run;
      end
    end
  endtask

  // stimulus sequence and final verdict
  initial begin
    rst             <= 1'b1;
    item_valid      <= 1'b0;
    kind            <= prsnt_pkg::KIND_ENC;
    data_block      <= '0;
    restart_counter <= 1'b0;
    cfg_valid       <= 1'b0;
    cfg_index       <= prsnt_pkg::REG_KEY_SIZE;
    cfg_data        <= '0;
    mdl_size128     = 1'b0;
    mdl_key_hi      = '0;
    mdl_key_lo      = '0;
    mdl_nonce       = '0;
    mdl_counter     = '0;
    mdl_keys_fresh  = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_key_extremes();
    test_nonce_keeps_counter();
    test_backpressure();
    test_random_traffic();
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("present_block_cipher_ctr_tb: PASS");
    end else begin
      $display("present_block_cipher_ctr_tb: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("present_block_cipher_ctr_tb: FAIL");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/prsnt_pkg.sv
hw/rtl/prsnt_ctrl.sv
hw/rtl/prsnt_dp.sv
hw/rtl/present_block_cipher_ctr.sv
test/present_block_cipher_ctr_tb.sv
